FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psl_checker: property failed");

// Next-cycle implication, disabled during reset.
`define PSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psl_checker: property failed");

`endif

FILE: hw/rtl/psl_pkg.sv
// Shared types and constants of the Poisson sampler.
package psl_pkg;

    localparam int SEED_W     = 48;
    localparam int CFG_DATA_W = 48;
    localparam int MSEED_W    = 32;
    localparam int COUNT_W    = 10;
    localparam int STREAM_W   = 3;

    localparam logic [31:0]         LCG_MUL_LO       = 32'hDEEC_E66D;
    localparam logic [2:0]          LCG_MUL_HI       = 3'h5;
    localparam logic [SEED_W-1:0]   LCG_ADD          = 48'hB;
    localparam logic [15:0]         SEED_LOW         = 16'h330E;
    localparam int                  WORDS_PER_STREAM = 3;
    localparam logic [MSEED_W-1:0]  MASTER_SEED_RST  = 32'd39362;
    localparam logic [SEED_W-1:0]   THRESHOLD_RST    = 48'h8000_0000_0000;

    typedef enum logic {
        ACT_INIT = 1'b0,
        ACT_DRAW = 1'b1
    } action_t;

    typedef enum logic [0:0] {
        REG_MASTER_SEED = 1'b0,
        REG_THRESHOLD   = 1'b1
    } cfg_index_t;

    typedef logic [STREAM_W-1:0] stream_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [SEED_W-1:0]   seed_t;

endpackage

FILE: hw/rtl/psl_if.sv
// Request and result channel interfaces of the Poisson sampler.
interface psl_in_if;
    import psl_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    stream_t stream;

    modport source (output valid, output action, output stream, input ready);
    modport sink   (input valid, input action, input stream, output ready);
endinterface

interface psl_out_if;
    import psl_pkg::*;

    logic   valid;
    logic   ready;
    count_t count;
    logic   saturated;

    modport source (output valid, output count, output saturated, input ready);
    modport sink   (input valid, input count, input saturated, output ready);
endinterface

FILE: hw/rtl/poisson_sampler_lcg48_streams.sv
// Poisson count sampler over drand48 streams kept in a state memory.
//
//  channel | dir | payload                 | handshake
//  req     | in  | action, stream          | valid/ready
//  rsp     | out | count, saturated        | valid/ready
//  cfg     | in  | cfg_index, cfg_wdata    | cfg_we, no wait
//
// A draw runs generator steps, products in the iterative 24x24 multiplier
// and threshold compares; a zero state is skipped with an extra generator
// step. An init runs WORDS_PER_STREAM generator steps for each stream.
// One item is in work at a time; a new request is taken while a result
// still waits in the output register. Reset clears all stream states to zero.
module poisson_sampler_lcg48_streams #(
    parameter int NUM_STREAMS = 8,
    parameter int MAX_COUNT   = 1023
) (
    input  logic                           clk,
    input  logic                           rst_n,
    psl_in_if.sink                         req,
    psl_out_if.source                      rsp,
    input  logic                           cfg_we,
    input  psl_pkg::cfg_index_t            cfg_index,
    input  logic [psl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import psl_pkg::*;

    localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int CW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT + 1) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_LCG   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    action_t              action_reg, action_next;
    logic [SW-1:0]        idx_reg, idx_next;
    seed_t                x_reg, x_next;
    seed_t                p_reg, p_next;
    logic [CW-1:0]        k_reg, k_next;
    logic                 sat_reg, sat_next;
    logic                 first_reg, first_next;
    logic [SW-1:0]        sidx_reg, sidx_next;
    logic [1:0]           word_reg, word_next;
    logic [31:0]          seed_acc_reg, seed_acc_next;
    logic                 lcg_start_reg, lcg_start_next;
    logic                 mul_start_reg, mul_start_next;
    logic                 out_valid_reg, out_valid_next;
    count_t               out_count_reg, out_count_next;
    logic                 out_sat_reg, out_sat_next;
    logic [MSEED_W-1:0]   master_seed_reg;
    seed_t                threshold_reg;

    stream_t              red;
    logic [SW-1:0]        stream_idx;
    logic                 mem_we;
    logic [SW-1:0]        mem_waddr;
    seed_t                mem_wdata;
    seed_t                mem_rdata;
    logic                 lcg_done;
    seed_t                lcg_y;
    logic                 mul_done;
    seed_t                mul_prod;

    psl_stream_mem #(
        .DEPTH (NUM_STREAMS),
        .AW    (SW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    psl_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lcg_start_reg),
        .x     (x_reg),
        .done  (lcg_done),
        .y     (lcg_y)
    );

    psl_fixmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (p_reg),
        .b     (x_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Stream index modulo the stream count, by repeated subtraction.
    always_comb
    begin
        red = req.stream;
        for (int i = 0; i < 7; i++)
        begin
            if (int'(red) >= NUM_STREAMS)
            begin
                red = red - 3'(NUM_STREAMS);
            end
        end
    end

    assign stream_idx = SW'(red);

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        sat_next       = sat_reg;
        first_next     = first_reg;
        sidx_next      = sidx_reg;
        word_next      = word_reg;
        seed_acc_next  = seed_acc_reg;
        lcg_start_next = 1'b0;
        mul_start_next = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_count_next = out_count_reg;
        out_sat_next   = out_sat_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = x_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    action_next = req.action;
                    idx_next    = stream_idx;
                    k_next      = '0;
                    sat_next    = 1'b0;
                    first_next  = 1'b1;
                    if (req.action == ACT_INIT)
                    begin
                        x_next         = {master_seed_reg, SEED_LOW};
                        sidx_next      = '0;
                        word_next      = '0;
                        lcg_start_next = 1'b1;
                        state_next     = S_LCG;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                x_next         = mem_rdata;
                lcg_start_next = 1'b1;
                state_next     = S_LCG;
            end
            S_LCG:
            begin
                if (lcg_done)
                begin
                    x_next = lcg_y;
                    if (action_reg == ACT_DRAW)
                    begin
                        if (lcg_y == '0)
                        begin
                            // skip a zero state
                            lcg_start_next = 1'b1;
                        end
                        else if (first_reg)
                        begin
                            p_next     = lcg_y;
                            first_next = 1'b0;
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            mul_start_next = 1'b1;
                            state_next     = S_MUL;
                        end
                    end
                    else if (word_reg == 2'(WORDS_PER_STREAM - 1))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = sidx_reg;
                        mem_wdata = {lcg_y[32:17], seed_acc_reg};
                        if (sidx_reg == SW'(NUM_STREAMS - 1))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            sidx_next      = sidx_reg + 1'b1;
                            word_next      = '0;
                            lcg_start_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (word_reg == '0)
                        begin
                            seed_acc_next[15:0] = lcg_y[32:17];
                        end
                        else
                        begin
                            seed_acc_next[31:16] = lcg_y[32:17];
                        end
                        word_next      = word_reg + 2'd1;
                        lcg_start_next = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    p_next     = mul_prod;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (p_reg <= threshold_reg)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else if (k_reg >= CW'(MAX_COUNT))
                begin
                    sat_next   = 1'b1;
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next         = k_reg + 1'b1;
                    lcg_start_next = 1'b1;
                    state_next     = S_LCG;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = COUNT_W'(k_reg);
                    out_sat_next   = sat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            lcg_start_reg   <= 1'b0;
            mul_start_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            master_seed_reg <= MASTER_SEED_RST;
            threshold_reg   <= THRESHOLD_RST;
        end
        else
        begin
            state_reg     <= state_next;
            lcg_start_reg <= lcg_start_next;
            mul_start_reg <= mul_start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MASTER_SEED: master_seed_reg <= cfg_wdata[MSEED_W-1:0];
                    REG_THRESHOLD:   threshold_reg   <= cfg_wdata[SEED_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        idx_reg       <= idx_next;
        x_reg         <= x_next;
        p_reg         <= p_next;
        k_reg         <= k_next;
        sat_reg       <= sat_next;
        first_reg     <= first_next;
        sidx_reg      <= sidx_next;
        word_reg      <= word_next;
        seed_acc_reg  <= seed_acc_next;
        out_count_reg <= out_count_next;
        out_sat_reg   <= out_sat_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.count     = out_count_reg;
    assign rsp.saturated = out_sat_reg;

endmodule

FILE: hw/rtl/psl_stream_mem.sv
// Stream state memory: one write port, one registered read port, valid bits per entry.
module psl_stream_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [psl_pkg::SEED_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [psl_pkg::SEED_W-1:0]  rdata
);
    import psl_pkg::*;

    seed_t            mem_reg [DEPTH];
    seed_t            rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    // An entry never written reads as zero.
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: hw/rtl/psl_lcg.sv
// One step of the 48-bit drand48 recurrence, with the products registered on start.
module psl_lcg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [psl_pkg::SEED_W-1:0]  x,
    output logic                        done,
    output logic [psl_pkg::SEED_W-1:0]  y
);
    import psl_pkg::*;

    logic [63:0] lo_full;
    logic [31:0] hi_a;
    logic [18:0] hi_b;
    logic [15:0] hi_sum;
    seed_t       lo_reg;
    logic [15:0] hi_reg;
    logic        busy_reg;

    // Low product in full, upper cross terms only modulo 2^16.
    assign lo_full = 64'(LCG_MUL_LO) * 64'(x[31:0]);
    assign hi_a    = 32'(LCG_MUL_LO[15:0]) * 32'(x[47:32]);
    assign hi_b    = 19'(LCG_MUL_HI) * 19'(x[15:0]);
    assign hi_sum  = hi_a[15:0] + hi_b[15:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg <= lo_full[47:0];
            hi_reg <= hi_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    assign done = busy_reg;
    assign y    = lo_reg + {hi_reg, 32'h0} + LCG_ADD;

endmodule

FILE: hw/rtl/psl_fixmul.sv
// Iterative 0.48 x 0.48 fixed-point product, one 24x24 partial product per cycle.
module psl_fixmul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [psl_pkg::SEED_W-1:0]  a,
    input  logic [psl_pkg::SEED_W-1:0]  b,
    output logic                        done,
    output logic [psl_pkg::SEED_W-1:0]  prod
);
    import psl_pkg::*;

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_LOW   = 3'd1;
    localparam logic [2:0] PH_LAST  = 3'd4;

    logic [2:0]  phase_reg;
    logic        busy_reg;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] mult;
    logic [47:0] pp_reg;
    logic [49:0] acc_reg;

    // Operands hold while busy; phase bits pick the halves.
    assign ma   = phase_reg[0] ? a[47:24] : a[23:0];
    assign mb   = phase_reg[1] ? b[47:24] : b[23:0];
    assign mult = 48'(ma) * 48'(mb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_FIRST;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= PH_FIRST;
        end
        else if (busy_reg)
        begin
            if (phase_reg == PH_LAST)
            begin
                busy_reg <= 1'b0;
            end
            phase_reg <= phase_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && phase_reg != PH_LAST)
        begin
            pp_reg <= mult;
            if (phase_reg == PH_LOW)
            begin
                acc_reg <= 50'(pp_reg >> 24);
            end
            else if (phase_reg != PH_FIRST)
            begin
                acc_reg <= acc_reg + 50'(pp_reg);
            end
        end
    end

    assign done = busy_reg && (phase_reg == PH_LAST);
    assign prod = pp_reg + 48'(acc_reg >> 24);

endmodule

FILE: hw/rtl/psl_checker.sv
// Port-level checker for the Poisson sampler, bound to the top level.
`include "assert_macros.svh"

module psl_checker #(
    parameter int MAX_COUNT = 1023
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [9:0] out_count,
    input logic       out_saturated
);

    `PSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PSL_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready)
    `PSL_ASSERT_NOW(a_sat_bound, clk, rst_n, out_valid && out_saturated, out_count == 10'(MAX_COUNT))
    `PSL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_count) && $stable(out_saturated))

endmodule

bind poisson_sampler_lcg48_streams psl_checker #(
    .MAX_COUNT (MAX_COUNT)
) u_psl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_count     (rsp.count),
    .out_saturated (rsp.saturated)
);

FILE: dv/poisson_sampler_lcg48_streams_tb.sv
// Self-checking testbench for the Poisson sampler over drand48 generator streams.
`timescale 1ns / 1ps

module poisson_sampler_lcg48_streams_tb;
    import psl_pkg::*;

    localparam int NUM_LANES   = 8;
    localparam int MAX_COUNT   = 1023;
    localparam int RAND_ITEMS  = 950;
    localparam int REPORT_MAX  = 20;
    localparam seed_t LCG_MUL48 = {13'b0, LCG_MUL_HI, LCG_MUL_LO};

    typedef struct packed {
        count_t count;
        logic   saturated;
    } poisson_result_t;

    class poisson_scoreboard;
        seed_t             lanes [NUM_LANES];
        logic [31:0]       mseed;
        seed_t             thresh;
        poisson_result_t   waiting [$];
        int                errors;
        int                draws;
        int                inits;
        int                checked;
        int                max_seen;
        int                zero_counts;
        int                sat_counts;

        function void reset_state();
            foreach (lanes[i])
                lanes[i] = '0;
            mseed  = MASTER_SEED_RST;
            thresh = THRESHOLD_RST;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MASTER_SEED)
                mseed = data[MSEED_W-1:0];
            else
                thresh = data[SEED_W-1:0];
        endfunction

        function seed_t lcg_step(seed_t v);
            return seed_t'(LCG_MUL48 * v + LCG_ADD);
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(action_t act, stream_t sel);
            poisson_result_t r;
            seed_t           m;
            seed_t           x;
            logic [48:0]     prod_p;
            logic [96:0]     prod;
            int              k;
            bit              done;
            r = '0;
            if (act == ACT_INIT) begin
                m = {mseed, SEED_LOW};
                for (int s = 0; s < NUM_LANES; s++) begin
                    lanes[s] = '0;
                    for (int w = 0; w < WORDS_PER_STREAM; w++) begin
                        m = lcg_step(m);
                        lanes[s][16*w +: 16] = m[32:17];
                    end
                end
                inits++;
            end else begin
                x      = lanes[sel];
                prod_p = 49'h1_0000_0000_0000;
                k      = 0;
                done   = 1'b0;
                while (!done) begin
                    x = lcg_step(x);
                    // a zero state is never a uniform: step again
                    if (x == '0)
                        x = lcg_step(x);
                    prod   = prod_p * x;
                    prod_p = prod[96:48];
                    k++;
                    if (prod_p <= {1'b0, thresh}) begin
                        r.count = count_t'(k - 1);
                        done    = 1'b1;
                    end else if (k - 1 >= MAX_COUNT) begin
                        r.count     = count_t'(MAX_COUNT);
                        r.saturated = 1'b1;
                        done        = 1'b1;
                    end
                end
                lanes[sel] = x;
                draws++;
            end
            waiting.push_back(r);
        endfunction

        function void check_result(count_t cnt, logic sat);
            poisson_result_t e;
            if (waiting.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $error("result with nothing expected: count %0d saturated %0d", cnt, sat);
                return;
            end
            e = waiting.pop_front();
            checked++;
            if (cnt !== e.count) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $error("count: expected %0d, actual %0d", e.count, cnt);
            end
            if (sat !== e.saturated) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $error("saturated: expected %0d, actual %0d", e.saturated, sat);
            end
            if (int'(e.count) > max_seen)
                max_seen = e.count;
            if (e.count == '0)
                zero_counts++;
            if (e.saturated)
                sat_counts++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    psl_in_if  req_if ();
    psl_out_if rsp_if ();

    poisson_scoreboard sb;

    int          burst_left;
    int          settings;
    int          issued;
    logic [15:0] stall_pattern;
    int          stall_age;

    poisson_sampler_lcg48_streams #(
        .NUM_STREAMS (NUM_LANES),
        .MAX_COUNT   (MAX_COUNT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #400_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Stall the result channel on a rotating pattern, reloaded when its age counter runs out.
    always @(negedge clk)
    begin
        if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern = '1;
                1: stall_pattern = 16'($urandom);
                2: stall_pattern = 16'($urandom) | 16'($urandom);
                default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h1;
            endcase
            stall_age = 64;
        end
        stall_age--;
        rsp_if.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.count, rsp_if.saturated);
    end

    // Offer one request, with a random gap between bursts, and hold it until taken.
    task automatic send_req(action_t act, stream_t sel);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge clk) req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.stream <= sel;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(act, sel);
    endtask

    task automatic drain();
        @(negedge clk) req_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.set_reg(idx, data);
        @(negedge clk) cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        action_t act;
        seed_t   thr;
        int      n;
        req_if.valid  = 1'b0;
        req_if.action = ACT_INIT;
        req_if.stream = '0;
        rsp_if.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MASTER_SEED;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        burst_left    = 0;
        settings      = 0;
        issued        = 0;
        stall_age     = 0;
        stall_pattern = '1;
        sb = new;
        sb.reset_state();
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // draws on never-seeded streams run from a zero state
        send_req(ACT_DRAW, 3'd0);
        send_req(ACT_DRAW, 3'd7);
        send_req(ACT_DRAW, 3'd0);
        send_req(ACT_INIT, 3'd5);
        for (int s = 0; s < NUM_LANES; s++)
            send_req(ACT_DRAW, stream_t'(s));
        drain();

        // threshold at full scale: the first product always stops the loop
        write_reg(REG_THRESHOLD, {CFG_DATA_W{1'b1}});
        send_req(ACT_DRAW, 3'd5);
        send_req(ACT_DRAW, 3'd2);
        drain();

        // threshold at zero: run until the product truncates to zero
        write_reg(REG_THRESHOLD, '0);
        send_req(ACT_DRAW, 3'd1);
        send_req(ACT_DRAW, 3'd6);
        drain();

        write_reg(REG_THRESHOLD, THRESHOLD_RST);
        write_reg(REG_MASTER_SEED, '0);
        send_req(ACT_INIT, 3'd0);
        send_req(ACT_DRAW, 3'd4);
        drain();
        write_reg(REG_MASTER_SEED, {{(CFG_DATA_W-MSEED_W){1'b0}}, {MSEED_W{1'b1}}});
        send_req(ACT_INIT, 3'd7);
        send_req(ACT_DRAW, 3'd7);
        drain();

        while (issued < RAND_ITEMS) begin
            case ($urandom_range(0, 7))
                0: thr = THRESHOLD_RST;
                1: thr = '1;
                2: thr = '0;
                3: thr = seed_t'({$urandom, $urandom});
                default: thr = seed_t'({$urandom, $urandom}) >> $urandom_range(1, 16);
            endcase
            write_reg(REG_THRESHOLD, thr);
            case ($urandom_range(0, 5))
                0: write_reg(REG_MASTER_SEED, MASTER_SEED_RST);
                1: write_reg(REG_MASTER_SEED, '0);
                2: write_reg(REG_MASTER_SEED, {{(CFG_DATA_W-MSEED_W){1'b0}}, {MSEED_W{1'b1}}});
                default: write_reg(REG_MASTER_SEED, CFG_DATA_W'($urandom));
            endcase
            if ($urandom_range(0, 2) == 0) begin
                send_req(ACT_INIT, stream_t'($urandom));
                issued++;
            end
            n = $urandom_range(30, 90);
            repeat (n) begin
                act = ($urandom_range(0, 9) == 0) ? ACT_INIT : ACT_DRAW;
                send_req(act, stream_t'($urandom));
                issued++;
            end
            drain();
        end

        repeat (64) @(posedge clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $error("%0d expected results never arrived", sb.pending());
        end
        $display("Checked %0d results: %0d draws, %0d stream seedings, %0d register writes.",
                 sb.checked, sb.draws, sb.inits, settings);
        $display("Largest count %0d, %0d zero counts, %0d saturated.",
                 sb.max_seen, sb.zero_counts, sb.sat_counts);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
